FILE: rtl/olt_pkg.sv
`timescale 1ns / 1ps

package olt_pkg;

  localparam int KIND_W        = 3;
  localparam int POSITION_W    = 7;
  localparam int HANDLE_W      = 32;
  localparam int COUNT_FIELD_W = 7;

  typedef enum logic [KIND_W-1:0] {
    K_INSERT_AT    = 3'd0,
    K_APPEND       = 3'd1,
    K_REMOVE_AT    = 3'd2,
    K_REMOVE_VALUE = 3'd3,
    K_CONTAINS     = 3'd4,
    K_GET          = 3'd5,
    K_SET          = 3'd6,
    K_CLEAR        = 3'd7
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SHIFT_UP,
    S_PUT_VALUE,
    S_SHIFT_DOWN,
    S_SEARCH,
    S_GET_WAIT,
    S_DONE
  } seq_state_t;

  typedef struct packed {
    kind_t                 kind;
    logic [POSITION_W-1:0] position;
    logic [HANDLE_W-1:0]   handle_value;
  } op_item_t;

  typedef struct packed {
    status_t                  status;
    logic                     found;
    logic [HANDLE_W-1:0]      read_value;
    logic [COUNT_FIELD_W-1:0] entry_count;
  } result_item_t;

endpackage

FILE: rtl/olt_ram.sv
`timescale 1ns / 1ps

module olt_ram #(
  parameter int DEPTH = 64,
  parameter int AW    = 6,
  parameter int DW    = 32
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: rtl/olt_seq.sv
`timescale 1ns / 1ps

module olt_seq #(
  parameter int CAPACITY    = 64,
  parameter int VALUE_WIDTH = 32,
  parameter int AW          = 6,
  parameter int CW          = 7
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  item_valid,
  input  olt_pkg::op_item_t     item,
  output logic                  item_stall,
  output logic                  res_valid,
  output olt_pkg::result_item_t res,
  input  logic                  res_take,
  output logic                  mem_wr_en,
  output logic [AW-1:0]         mem_wr_addr,
  output logic [VALUE_WIDTH-1:0] mem_wr_data,
  output logic                  mem_rd_en,
  output logic [AW-1:0]         mem_rd_addr,
  input  logic [VALUE_WIDTH-1:0] mem_rd_data
);

  import olt_pkg::*;

  localparam int CMPW = (CW > COUNT_FIELD_W) ? CW : COUNT_FIELD_W;

  seq_state_t state, state_next;
  logic [CW-1:0] cnt, cnt_next;

  kind_t                  kind_r, kind_r_next;
  logic [AW-1:0]          pos_r, pos_r_next;
  logic [VALUE_WIDTH-1:0] val_r, val_r_next;
  logic [AW-1:0]          idx, idx_next;
  status_t                res_status, res_status_next;
  logic                   res_found, res_found_next;
  logic [HANDLE_W-1:0]    res_read, res_read_next;

  logic [CMPW-1:0] pos_c, cnt_c, ins_at, pos_p1;
  logic [CW-1:0]   cnt_m1;
  logic [63:0]     hv_wide, rd_wide;
  logic [VALUE_WIDTH-1:0] val_in;
  logic ins_range, is_full, ins_tail, in_range, rem_tail, list_empty;
  logic hit, scan_last, shdn_last, up_last;

  always_comb begin
    pos_c      = CMPW'(item.position);
    cnt_c      = CMPW'(cnt);
    ins_at     = (item.kind == K_APPEND) ? cnt_c : pos_c;
    ins_range  = ins_at > cnt_c;
    is_full    = cnt == CW'(CAPACITY);
    ins_tail   = ins_at == cnt_c;
    in_range   = pos_c < cnt_c;
    pos_p1     = pos_c + CMPW'(1);
    rem_tail   = pos_p1 == cnt_c;
    list_empty = cnt == '0;
    cnt_m1     = cnt - CW'(1);
    hv_wide    = 64'(item.handle_value);
    val_in     = hv_wide[VALUE_WIDTH-1:0];
    rd_wide    = 64'(mem_rd_data);
    hit        = mem_rd_data == val_r;
    scan_last  = (CW'(idx) + CW'(1)) == cnt;
    shdn_last  = (CW'(idx) + CW'(2)) == cnt;
    up_last    = idx == (pos_r + AW'(1));
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (item_valid) begin
          unique case (item.kind) inside
            K_INSERT_AT, K_APPEND: begin
              state_next = (ins_range || is_full || ins_tail) ? S_DONE : S_SHIFT_UP;
            end
            K_REMOVE_AT: begin
              state_next = (!in_range || rem_tail) ? S_DONE : S_SHIFT_DOWN;
            end
            K_REMOVE_VALUE, K_CONTAINS: begin
              state_next = list_empty ? S_DONE : S_SEARCH;
            end
            K_GET: begin
              state_next = in_range ? S_GET_WAIT : S_DONE;
            end
            K_SET, K_CLEAR: begin
              state_next = S_DONE;
            end
          endcase
        end
      end
      S_SHIFT_UP: begin
        if (up_last) state_next = S_PUT_VALUE;
      end
      S_PUT_VALUE: begin
        state_next = S_DONE;
      end
      S_SHIFT_DOWN: begin
        if (shdn_last) state_next = S_DONE;
      end
      S_SEARCH: begin
        if (hit) begin
          state_next = (kind_r == K_CONTAINS || scan_last) ? S_DONE : S_SHIFT_DOWN;
        end else if (scan_last) begin
          state_next = S_DONE;
        end
      end
      S_GET_WAIT: begin
        state_next = S_DONE;
      end
      S_DONE: begin
        if (res_take) state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // memory accesses and register updates
  always_comb begin
    item_stall      = state != S_IDLE;
    res_valid       = state == S_DONE;
    mem_wr_en       = 1'b0;
    mem_wr_addr     = idx;
    mem_wr_data     = mem_rd_data;
    mem_rd_en       = 1'b0;
    mem_rd_addr     = idx;
    cnt_next        = cnt;
    idx_next        = idx;
    kind_r_next     = kind_r;
    pos_r_next      = pos_r;
    val_r_next      = val_r;
    res_status_next = res_status;
    res_found_next  = res_found;
    res_read_next   = res_read;
    unique case (state)
      S_IDLE: begin
        if (item_valid) begin
          kind_r_next     = item.kind;
          pos_r_next      = ins_at[AW-1:0];
          val_r_next      = val_in;
          res_status_next = ST_OK;
          res_found_next  = 1'b0;
          res_read_next   = '0;
          unique case (item.kind) inside
            K_INSERT_AT, K_APPEND: begin
              if (ins_range) begin
                res_status_next = ST_RANGE;
              end else if (is_full) begin
                res_status_next = ST_FULL;
              end else if (ins_tail) begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = ins_at[AW-1:0];
                mem_wr_data = val_in;
                cnt_next    = cnt + CW'(1);
              end else begin
                // walk down from the tail, moving each entry up one place
                mem_rd_en   = 1'b1;
                mem_rd_addr = cnt_m1[AW-1:0];
                idx_next    = cnt[AW-1:0];
              end
            end
            K_REMOVE_AT: begin
              if (!in_range) begin
                res_status_next = ST_RANGE;
              end else if (rem_tail) begin
                cnt_next = cnt_m1;
              end else begin
                mem_rd_en   = 1'b1;
                mem_rd_addr = pos_p1[AW-1:0];
                idx_next    = pos_c[AW-1:0];
              end
            end
            K_REMOVE_VALUE, K_CONTAINS: begin
              if (list_empty) begin
                if (item.kind == K_REMOVE_VALUE) res_status_next = ST_RANGE;
              end else begin
                mem_rd_en   = 1'b1;
                mem_rd_addr = '0;
                idx_next    = '0;
              end
            end
            K_GET: begin
              if (in_range) begin
                mem_rd_en   = 1'b1;
                mem_rd_addr = pos_c[AW-1:0];
              end else begin
                res_status_next = ST_RANGE;
              end
            end
            K_SET: begin
              if (in_range) begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = pos_c[AW-1:0];
                mem_wr_data = val_in;
              end else begin
                res_status_next = ST_RANGE;
              end
            end
            K_CLEAR: begin
              cnt_next = '0;
            end
          endcase
        end
      end
      S_SHIFT_UP: begin
        mem_wr_en = 1'b1;
        if (!up_last) begin
          mem_rd_en   = 1'b1;
          mem_rd_addr = idx - AW'(2);
          idx_next    = idx - AW'(1);
        end
      end
      S_PUT_VALUE: begin
        mem_wr_en   = 1'b1;
        mem_wr_addr = pos_r;
        mem_wr_data = val_r;
        cnt_next    = cnt + CW'(1);
      end
      S_SHIFT_DOWN: begin
        mem_wr_en = 1'b1;
        if (shdn_last) begin
          cnt_next = cnt_m1;
        end else begin
          mem_rd_en   = 1'b1;
          mem_rd_addr = idx + AW'(2);
          idx_next    = idx + AW'(1);
        end
      end
      S_SEARCH: begin
        if (hit) begin
          if (kind_r == K_CONTAINS) begin
            res_found_next = 1'b1;
          end else if (scan_last) begin
            cnt_next = cnt_m1;
          end else begin
            // idx stays on the match, which becomes the first write target
            mem_rd_en   = 1'b1;
            mem_rd_addr = idx + AW'(1);
          end
        end else if (scan_last) begin
          if (kind_r == K_REMOVE_VALUE) res_status_next = ST_RANGE;
        end else begin
          mem_rd_en   = 1'b1;
          mem_rd_addr = idx + AW'(1);
          idx_next    = idx + AW'(1);
        end
      end
      S_GET_WAIT: begin
        res_read_next = rd_wide[HANDLE_W-1:0];
      end
      S_DONE: begin
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    res.status      = res_status;
    res.found       = res_found;
    res.read_value  = res_read;
    res.entry_count = cnt_c[COUNT_FIELD_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    kind_r     <= kind_r_next;
    pos_r      <= pos_r_next;
    val_r      <= val_r_next;
    idx        <= idx_next;
    res_status <= res_status_next;
    res_found  <= res_found_next;
    res_read   <= res_read_next;
  end

endmodule

FILE: rtl/ordered_list_table_engine.sv
`timescale 1ns / 1ps

// channel   direction  payload          handshake
// op        in         op_item_t        op_valid / op_stall
// result    out        result_item_t    result_valid / result_stall
//
// one item at a time; append, set, clear and inserts or removes at the tail go straight
// from idle to done, while get passes through a read wait state first
// shifting inserts move entries through the shift-up state and then write the new value, shifting removes
// move entries through the shift-down state, searches read the entries in turn and a value remove
// shifts the later entries down after a match; the entry memory moves one entry per cycle through its
// one read and one write port; reset clears the count and the control state; the entry memory is not cleared
// a finished item waits in the output register while the next item is accepted

module ordered_list_table_engine #(
  parameter int CAPACITY    = 64,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  op_valid,
  output logic                  op_stall,
  input  olt_pkg::op_item_t     op,
  output logic                  result_valid,
  input  logic                  result_stall,
  output olt_pkg::result_item_t result
);

  import olt_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [COUNT_FIELD_W-1:0] CAP_LOW = COUNT_FIELD_W'(CAPACITY);

  logic                   res_valid, res_take;
  result_item_t           res;
  logic                   mem_wr_en, mem_rd_en;
  logic [AW-1:0]          mem_wr_addr, mem_rd_addr;
  logic [VALUE_WIDTH-1:0] mem_wr_data, mem_rd_data;

  olt_ram #(
    .DEPTH (CAPACITY),
    .AW    (AW),
    .DW    (VALUE_WIDTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  olt_seq #(
    .CAPACITY    (CAPACITY),
    .VALUE_WIDTH (VALUE_WIDTH),
    .AW          (AW),
    .CW          (CW)
  ) u_seq (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (op_valid),
    .item        (op),
    .item_stall  (op_stall),
    .res_valid   (res_valid),
    .res         (res),
    .res_take    (res_take),
    .mem_wr_en   (mem_wr_en),
    .mem_wr_addr (mem_wr_addr),
    .mem_wr_data (mem_wr_data),
    .mem_rd_en   (mem_rd_en),
    .mem_rd_addr (mem_rd_addr),
    .mem_rd_data (mem_rd_data)
  );

  // output register: loads when empty or being drained
  assign res_take = !result_valid || !result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (res_valid && res_take) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_take) begin
      result <= res;
    end
  end

  a_one_item_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (op_valid && !op_stall) |=> op_stall)
    else $error("item accepted while another is in progress");

  a_full_means_at_capacity: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.status == ST_FULL) |-> result.entry_count == CAP_LOW)
    else $error("full status with list below capacity");

  a_found_is_clean: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.found) |-> (result.status == ST_OK && result.read_value == '0))
    else $error("found flag with error status or read value");

  a_handoff_needs_room: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_take) |=> res_valid)
    else $error("finished item dropped before the output register took it");

endmodule
